// ===== src/atr_pkg.sv =====
// Package for the alpha triangle rasterizer.
// Holds store geometry, op codes, interface structs and the blend function.
// No dependencies.
package atr_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [22:0] mag;
    logic [10:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       wdata;
  } fs_req_t;

  function automatic logic [7:0] blend_chan(logic [7:0] fill, logic [7:0] old,
                                            logic [7:0] a);
    logic [15:0] sum;
    sum = 16'(fill * a) + 16'(old * (8'd255 - a));
    return sum[15:8];
  endfunction

endpackage

// ===== src/atr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Divides a 23-bit magnitude by an 11-bit divisor, truncates toward zero.
// Depends on atr_pkg.
module atr_div import atr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [11:0] rem_q, rem_d;
  logic [22:0] quo_q, quo_d;
  logic [10:0] dvs_q;
  logic        neg_q;
  logic        run_q, run_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [11:0] shifted;
  logic        fits;

  always_comb begin
    shifted = {rem_q[10:0], quo_q[22]};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? shifted - {1'b0, dvs_q} : shifted;
    quo_d   = {quo_q[21:0], fits};
    run_d   = run_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (run_q) begin
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= 5'd22;
      end else begin
        run_q <= run_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.mag;
      dvs_q <= req_i.dvs;
      neg_q <= req_i.neg;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, quo_q[14:0]}) : $signed({1'b0, quo_q[14:0]});

endmodule

// ===== src/atr_fstore.sv =====
// Frame store: 24-bit pixel memory, one access per cycle, registered read.
// Depends on atr_pkg.
module atr_fstore import atr_pkg::*; (
  input  logic        clk_i,
  input  fs_req_t     req_i,
  output logic [23:0] rdata_o
);

  logic [23:0] mem [STORE_DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/alpha_triangle_rasterizer.sv =====
// Top level of the alpha triangle rasterizer.
// Depends on atr_pkg, atr_div and atr_fstore.
//
// Usage: drive an item on op_i and the payload ports and raise start; it is
// taken at a clock edge where busy is low. busy stays high until the item
// finishes; done_o then pulses for one cycle with op_done_o and the pixel
// color (zero unless the op is read). The receiver cannot stall.
// Steps per item:
//   read: a store read, then the registered result. unused op: only the finish step.
//   clear: one store word written per cycle over the whole store.
//   draw: per scanline in [0,height): row control, then per span end the
//   shared multiplier and then the bit-serial divider (a flat top row needs
//   one end), then per covered pixel a store read and a blended write-back;
//   rows outside the image only take row control.
// Configuration: cfg_we_i, cfg_index_i, cfg_data_i write width or height;
// the user must do so only while the block is idle; the block does not enforce it.
// Reset: width and height return to 256 and a clearing pass zeroes the
// frame store; busy is high during it and no done_o is given.
module alpha_triangle_rasterizer import atr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [8:0]              cfg_data_i,
  input  logic [1:0]              op_i,
  input  logic signed [9:0]       vert_a_x_i,
  input  logic signed [9:0]       vert_a_y_i,
  input  logic signed [9:0]       vert_b_x_i,
  input  logic signed [9:0]       vert_b_y_i,
  input  logic signed [9:0]       vert_c_x_i,
  input  logic signed [9:0]       vert_c_y_i,
  input  logic [7:0]              fill_red_i,
  input  logic [7:0]              fill_green_i,
  input  logic [7:0]              fill_blue_i,
  input  logic [7:0]              opacity_i,
  input  logic [15:0]             read_address_i,
  output logic                    done_o,
  output logic [7:0]              pixel_red_o,
  output logic [7:0]              pixel_green_o,
  output logic [7:0]              pixel_blue_o,
  output logic [1:0]              op_done_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_ROW  = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DWT  = 4'd8;
  localparam logic [3:0] S_RB   = 4'd9;
  localparam logic [3:0] S_SPAN = 4'd10;
  localparam logic [3:0] S_PRD  = 4'd11;
  localparam logic [3:0] S_PWR  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  localparam logic [8:0] MaxW = 9'(MAX_WIDTH);
  localparam logic [8:0] MaxH = 9'(MAX_HEIGHT);

  logic [3:0]  state_q;
  logic [8:0]  width_q, height_q;
  logic [8:0]  w_eff, h_eff;
  logic        report_q;
  logic [1:0]  op_q;
  logic [ADDR_W-1:0] clr_q;
  logic [ADDR_W-1:0] addr_q;
  logic        done_q;
  logic [23:0] pix_q;
  logic [1:0]  opd_q;

  logic signed [9:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [7:0]  r_q, g_q, b_q, a_q;
  logic signed [10:0] cy_q;
  logic        end_sel_q;
  logic signed [21:0] p_q, t_q;
  logic signed [15:0] e0_q, e1_q;
  logic [15:0] rowbase_q;
  logic [7:0]  cx_q, hi_q;

  // vertex sort
  logic signed [9:0] sx [3];
  logic signed [9:0] sy [3];
  logic signed [9:0] tx, ty;

  always_comb begin
    sx[0] = vert_a_x_i; sy[0] = vert_a_y_i;
    sx[1] = vert_b_x_i; sy[1] = vert_b_y_i;
    sx[2] = vert_c_x_i; sy[2] = vert_c_y_i;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    tx = sx[0];
    ty = sy[0];
  end

  assign w_eff = (width_q > MaxW) ? MaxW : width_q;
  assign h_eff = (height_q > MaxH) ? MaxH : height_q;

  // span end operands
  logic        upper;
  logic signed [10:0] base_c, dx_c, dy_c, dd_c;
  logic [9:0]  den_c;

  always_comb begin
    upper = cy_q <= 11'(y1_q);
    if (!end_sel_q) begin
      base_c = 11'(x0_q);
      dx_c   = 11'(x2_q) - 11'(x0_q);
      dy_c   = cy_q - 11'(y0_q);
      dd_c   = 11'(y2_q) - 11'(y0_q);
    end else if (upper) begin
      base_c = 11'(x0_q);
      dx_c   = 11'(x1_q) - 11'(x0_q);
      dy_c   = cy_q - 11'(y0_q);
      dd_c   = 11'(y1_q) - 11'(y0_q);
    end else begin
      base_c = 11'(x1_q);
      dx_c   = 11'(x2_q) - 11'(x1_q);
      dy_c   = cy_q - 11'(y1_q);
      dd_c   = 11'(y2_q) - 11'(y1_q);
    end
    den_c = dd_c[9:0];
  end

  // shared multiplier
  logic signed [10:0] mul_a, mul_b;
  logic signed [21:0] prod;

  always_comb begin
    case (state_q)
      S_M1: begin
        mul_a = dx_c;
        mul_b = dy_c;
      end
      S_M2: begin
        mul_a = base_c;
        mul_b = $signed({1'b0, den_c});
      end
      S_RB: begin
        mul_a = $signed({3'b0, cy_q[7:0]});
        mul_b = $signed({2'b0, w_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // rounded numerator 2*base*den + 2*num + den
  logic signed [23:0] n_c;
  logic [23:0] n_mag;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    n_c   = $signed({t_q[21], t_q, 1'b0}) + $signed({p_q[21], p_q, 1'b0})
          + $signed({14'b0, den_c});
    n_mag = n_c[23] ? 24'(-n_c) : 24'(n_c);
    div_req.start = state_q == S_DIV;
    div_req.neg   = n_c[23];
    div_req.mag   = n_mag[22:0];
    div_req.dvs   = {den_c, 1'b0};
  end

  atr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // span clipping
  logic signed [15:0] lo_c, hi_c, wm1;

  always_comb begin
    lo_c = (e0_q < e1_q) ? e0_q : e1_q;
    hi_c = (e0_q < e1_q) ? e1_q : e0_q;
    wm1  = $signed({7'b0, w_eff}) - 16'sd1;
    if (lo_c < 16'sd0) lo_c = 16'sd0;
    if (hi_c > wm1)    hi_c = wm1;
  end

  // frame store
  fs_req_t     fs_req;
  logic [23:0] fs_rdata;
  logic [23:0] blended;

  always_comb begin
    blended = {blend_chan(r_q, fs_rdata[23:16], a_q),
               blend_chan(g_q, fs_rdata[15:8], a_q),
               blend_chan(b_q, fs_rdata[7:0], a_q)};
    fs_req.we    = 1'b0;
    fs_req.re    = 1'b0;
    fs_req.addr  = addr_q;
    fs_req.wdata = blended;
    case (state_q)
      S_CLR: begin
        fs_req.we    = 1'b1;
        fs_req.addr  = clr_q;
        fs_req.wdata = '0;
      end
      S_RD: fs_req.re = 1'b1;
      S_PRD: begin
        fs_req.re   = 1'b1;
        fs_req.addr = rowbase_q[ADDR_W-1:0] + ADDR_W'(cx_q);
      end
      S_PWR: fs_req.we = 1'b1;
      default: ;
    endcase
  end

  atr_fstore u_fstore (
    .clk_i   (clk_i),
    .req_i   (fs_req),
    .rdata_o (fs_rdata)
  );

  // sequencer
  logic accept;
  assign accept = start && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      width_q   <= MaxW;
      height_q  <= MaxH;
      report_q  <= 1'b0;
      clr_q     <= '0;
      done_q    <= 1'b0;
      end_sel_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH)  width_q  <= cfg_data_i;
        if (cfg_index_i == CFG_HEIGHT) height_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            report_q <= 1'b1;
            case (op_i)
              OP_CLEAR: begin
                clr_q   <= '0;
                state_q <= S_CLR;
              end
              OP_DRAW: state_q <= (sy[2] == ty) ? S_FIN : S_ROW;
              OP_READ: state_q <= S_RD;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
            done_q  <= report_q;
          end
        end
        S_RD:  state_q <= S_RDW;
        S_RDW: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_ROW: begin
          end_sel_q <= 1'b0;
          if (cy_q > 11'(y2_q)) begin
            state_q <= S_FIN;
          end else if (cy_q < 11'sd0 || cy_q >= $signed({2'b0, h_eff})) begin
            state_q <= S_ROW;
          end else begin
            state_q <= S_M1;
          end
        end
        S_M1:  state_q <= S_M2;
        S_M2:  state_q <= S_DIV;
        S_DIV: state_q <= S_DWT;
        S_DWT: begin
          if (div_rsp.done) begin
            if (!end_sel_q) begin
              if (upper && y1_q == y0_q) begin
                state_q <= S_RB;
              end else begin
                end_sel_q <= 1'b1;
                state_q   <= S_M1;
              end
            end else begin
              state_q <= S_RB;
            end
          end
        end
        S_RB:  state_q <= S_SPAN;
        S_SPAN: state_q <= (lo_c > hi_c) ? S_ROW : S_PRD;
        S_PRD: state_q <= S_PWR;
        S_PWR: state_q <= (cx_q == hi_q) ? S_ROW : S_PRD;
        S_FIN: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      x0_q  <= tx;    y0_q <= ty;
      x1_q  <= sx[1]; y1_q <= sy[1];
      x2_q  <= sx[2]; y2_q <= sy[2];
      cy_q  <= 11'(ty);
      r_q   <= fill_red_i;
      g_q   <= fill_green_i;
      b_q   <= fill_blue_i;
      a_q   <= opacity_i;
      addr_q <= read_address_i[ADDR_W-1:0];
      pix_q <= '0;
      opd_q <= op_i;
    end
    case (state_q)
      S_ROW: begin
        if (cy_q <= 11'(y2_q) &&
            (cy_q < 11'sd0 || cy_q >= $signed({2'b0, h_eff}))) begin
          cy_q <= cy_q + 11'sd1;
        end
      end
      S_M1: p_q <= prod;
      S_M2: t_q <= prod;
      S_DWT: begin
        if (div_rsp.done) begin
          if (!end_sel_q) begin
            e0_q <= div_rsp.quo;
            e1_q <= 16'(x0_q);
          end else begin
            e1_q <= div_rsp.quo;
          end
        end
      end
      S_RB: rowbase_q <= prod[15:0];
      S_SPAN: begin
        cx_q <= lo_c[7:0];
        hi_q <= hi_c[7:0];
        if (lo_c > hi_c) cy_q <= cy_q + 11'sd1;
      end
      S_PRD: addr_q <= rowbase_q[ADDR_W-1:0] + ADDR_W'(cx_q);
      S_PWR: begin
        if (cx_q == hi_q) begin
          cy_q <= cy_q + 11'sd1;
        end else begin
          cx_q <= cx_q + 8'd1;
        end
      end
      S_RDW: pix_q <= (op_q == OP_READ) ? fs_rdata : '0;
      default: ;
    endcase
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign pixel_red_o   = pix_q[23:16];
  assign pixel_green_o = pix_q[15:8];
  assign pixel_blue_o  = pix_q[7:0];
  assign op_done_o     = opd_q;

endmodule

// ===== src/atr_checker.sv =====
// Port-level checker for the alpha triangle rasterizer, with its bind.
// Depends on atr_pkg.
module atr_checker import atr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] pixel_red_o,
  input logic [7:0] pixel_green_o,
  input logic [7:0] pixel_blue_o,
  input logic [1:0] op_done_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");

  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && op_done_o != OP_READ |->
      pixel_red_o == 8'd0 && pixel_green_o == 8'd0 && pixel_blue_o == 8'd0)
    else $error("nonzero color for a non-read item");

endmodule

bind alpha_triangle_rasterizer atr_checker u_atr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .pixel_red_o   (pixel_red_o),
  .pixel_green_o (pixel_green_o),
  .pixel_blue_o  (pixel_blue_o),
  .op_done_o     (op_done_o)
);
